// ----- rtl/mqmb_pkg.sv -----
// Shared types and constants for the multi-queue mailbox engine.
package mqmb_pkg;

  typedef enum logic [2:0] {
    CMD_SEND    = 3'd0,
    CMD_RESPOND = 3'd1,
    CMD_NOTIFY  = 3'd2,
    CMD_RECEIVE = 3'd3,
    CMD_RELEASE = 3'd4
  } cmd_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE = 3'd1;
  localparam logic [2:0] ST_BAD_ID    = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  localparam logic [7:0] MAX_BYTES = 8'd8;

  localparam logic CFG_RESP_KIND  = 1'b0;
  localparam logic CFG_EVENT_KIND = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input item, start slot read
    logic execute;  // apply update, build result
  } dp_cmd_t;

endpackage

// ----- rtl/mqmb_ctrl.sv -----
// Controller: sequences load, execute and result hand-off for one command.
module mqmb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output mqmb_pkg::dp_cmd_t  dp_cmd
);
  import mqmb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic in_xfer;
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign dp_cmd.load    = in_xfer;
  assign dp_cmd.execute = (state_r == S_EXEC);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

// ----- rtl/mqmb_datapath.sv -----
// Datapath: slot table, ring memory, counters and result registers.
module mqmb_datapath #(
  parameter int MAILBOX_SLOTS = 16,
  parameter int RING_DEPTH    = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mqmb_pkg::dp_cmd_t dp_cmd,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [2:0]        in_cmd,
  input  logic [31:0]       in_caller_id,
  input  logic [3:0]        in_target_slot,
  input  logic [31:0]       in_target_id,
  input  logic [31:0]       in_msg_kind,
  input  logic [63:0]       in_payload,
  input  logic [7:0]        in_data_size,
  output logic [2:0]        out_status,
  output logic [31:0]       out_src_id,
  output logic [31:0]       out_recv_kind,
  output logic [63:0]       out_recv_payload,
  output logic [3:0]        out_recv_size,
  output logic [4:0]        out_active_mailboxes,
  output logic [8:0]        out_total_queued,
  output logic [31:0]       out_total_sent
);
  import mqmb_pkg::*;

  localparam int SW = (MAILBOX_SLOTS > 1) ? $clog2(MAILBOX_SLOTS) : 1;
  localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FW = $clog2(RING_DEPTH + 1);
  localparam int EW = SW + PW;
  // entries are addressed as {slot, pointer}
  localparam int EDEPTH = MAILBOX_SLOTS << PW;
  localparam int MW = 32 + 32 + 64 + 4;

  logic [31:0] resp_kind_r, event_kind_r;
  logic        slot_valid_r [MAILBOX_SLOTS];
  logic [31:0] slot_owner_r [MAILBOX_SLOTS];
  logic [PW-1:0] rd_ptr_r [MAILBOX_SLOTS];
  logic [PW-1:0] wr_ptr_r [MAILBOX_SLOTS];
  logic [FW-1:0] fill_r [MAILBOX_SLOTS];
  logic [MW-1:0] ring_mem [EDEPTH];
  logic [MW-1:0] rd_data_r;

  logic [31:0] next_id_r, sent_r;
  logic [4:0]  active_r;
  logic [8:0]  queued_r;

  // captured item
  logic [2:0]  cmd_r;
  logic [31:0] caller_r, tid_r, kind_r;
  logic [63:0] pay_r;
  logic [7:0]  size_r;
  logic [SW-1:0] slot_r;
  logic        slot_ok_r;

  logic slot_in_range;
  assign slot_in_range = ({28'd0, in_target_slot} < 32'(MAILBOX_SLOTS));

  // read the head entry of the targeted slot during load
  logic [SW-1:0] ld_slot;
  logic [EW-1:0] rd_addr;
  assign ld_slot = SW'(in_target_slot);
  assign rd_addr = {ld_slot, rd_ptr_r[ld_slot]};

  always_ff @(posedge clk) begin
    if (dp_cmd.load) rd_data_r <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r     <= in_cmd;
      caller_r  <= in_caller_id;
      tid_r     <= in_target_id;
      kind_r    <= in_msg_kind;
      pay_r     <= in_payload;
      size_r    <= in_data_size;
      slot_r    <= ld_slot;
      slot_ok_r <= slot_in_range;
    end
  end

  // execute stage decisions
  logic is_enq, enq_size_bad, enq_id_bad, own_match, claim, full, enq_ok;
  logic is_recv, recv_ok, rel_ok;
  logic [31:0] enq_owner, enq_kind;
  logic [63:0] enq_data, byte_mask;
  logic [7:0]  enq_bytes;
  logic [FW-1:0] cur_fill;
  logic [2:0]  st;
  logic [8:0]  queued_nxt;
  logic [4:0]  active_nxt;

  always_comb begin
    is_enq  = (cmd_r == CMD_SEND) || (cmd_r == CMD_RESPOND) || (cmd_r == CMD_NOTIFY);
    is_recv = (cmd_r == CMD_RECEIVE);
    enq_kind  = (cmd_r == CMD_SEND) ? kind_r :
                (cmd_r == CMD_RESPOND) ? resp_kind_r : event_kind_r;
    enq_bytes = (cmd_r == CMD_RESPOND) ? MAX_BYTES : size_r;
    enq_size_bad = (cmd_r == CMD_RESPOND) ? (size_r != 8'd0) : (size_r > MAX_BYTES);
    enq_id_bad = (tid_r == 32'd0) || !slot_ok_r;
    enq_owner = is_enq ? tid_r : caller_r;
    own_match = slot_valid_r[slot_r] && (slot_owner_r[slot_r] == enq_owner);
    claim = slot_ok_r && !own_match &&
            ((is_enq && !enq_size_bad && !enq_id_bad) || is_recv);
    cur_fill = claim ? '0 : fill_r[slot_r];
    full = (32'(cur_fill) >= RING_DEPTH);
    enq_ok = is_enq && !enq_size_bad && !enq_id_bad && !full;
    recv_ok = is_recv && slot_ok_r && (cur_fill != '0);
    rel_ok = (cmd_r == CMD_RELEASE) && (caller_r != 32'd0) && slot_ok_r &&
             slot_valid_r[slot_r] && (slot_owner_r[slot_r] == caller_r);
    byte_mask = (enq_bytes >= MAX_BYTES) ? '1 :
                ((64'd1 << {enq_bytes[2:0], 3'b000}) - 64'd1);
    enq_data = pay_r & byte_mask;

    st = ST_OK;
    if (is_enq) begin
      if (enq_size_bad) st = ST_TOO_LARGE;
      else if (enq_id_bad) st = ST_BAD_ID;
      else if (full) st = ST_FULL;
    end else if (is_recv) begin
      if (!slot_ok_r) st = ST_BAD_ID;
      else if (cur_fill == '0) st = ST_EMPTY;
    end

    queued_nxt = queued_r;
    active_nxt = active_r;
    if (claim) begin
      if (slot_valid_r[slot_r]) queued_nxt = queued_nxt - 9'(fill_r[slot_r]);
      else active_nxt = active_nxt + 5'd1;
    end
    if (enq_ok) queued_nxt = queued_nxt + 9'd1;
    if (recv_ok) queued_nxt = queued_nxt - 9'd1;
    if (rel_ok) begin
      queued_nxt = queued_nxt - 9'(fill_r[slot_r]);
      active_nxt = active_nxt - 5'd1;
    end
  end

  logic [PW-1:0] wp_cur, rp_cur;
  assign wp_cur = claim ? '0 : wr_ptr_r[slot_r];
  assign rp_cur = claim ? '0 : rd_ptr_r[slot_r];

  always_ff @(posedge clk) begin
    if (dp_cmd.execute && enq_ok)
      ring_mem[{slot_r, wp_cur}] <= {caller_r, enq_kind, enq_data, enq_bytes[3:0]};
  end

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (32'(p) == RING_DEPTH - 1) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_kind_r  <= 32'd1;
      event_kind_r <= 32'd2;
      next_id_r <= 32'd1;
      sent_r    <= '0;
      active_r  <= '0;
      queued_r  <= '0;
      for (int i = 0; i < MAILBOX_SLOTS; i++) begin
        slot_valid_r[i] <= 1'b0;
        slot_owner_r[i] <= '0;
        rd_ptr_r[i] <= '0;
        wr_ptr_r[i] <= '0;
        fill_r[i]   <= '0;
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_RESP_KIND) resp_kind_r <= cfg_data;
        else event_kind_r <= cfg_data;
      end
      if (dp_cmd.execute) begin
        if (cmd_r == CMD_SEND) next_id_r <= next_id_r + 32'd1;
        if (enq_ok) sent_r <= sent_r + 32'd1;
        active_r <= active_nxt;
        queued_r <= queued_nxt;
        if (claim) begin
          slot_valid_r[slot_r] <= 1'b1;
          slot_owner_r[slot_r] <= enq_owner;
        end
        if (claim || enq_ok || recv_ok) begin
          wr_ptr_r[slot_r] <= enq_ok ? ptr_inc(wp_cur) : wp_cur;
          rd_ptr_r[slot_r] <= recv_ok ? ptr_inc(rp_cur) : rp_cur;
          fill_r[slot_r] <= enq_ok ? cur_fill + FW'(1) :
                            recv_ok ? cur_fill - FW'(1) : cur_fill;
        end
        if (rel_ok) begin
          slot_valid_r[slot_r] <= 1'b0;
          slot_owner_r[slot_r] <= '0;
          rd_ptr_r[slot_r] <= '0;
          wr_ptr_r[slot_r] <= '0;
          fill_r[slot_r]   <= '0;
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (dp_cmd.execute) begin
      out_status       <= st;
      out_src_id       <= recv_ok ? rd_data_r[MW-1 -: 32] : '0;
      out_recv_kind    <= recv_ok ? rd_data_r[MW-33 -: 32] : '0;
      out_recv_payload <= recv_ok ? rd_data_r[67:4] : '0;
      out_recv_size    <= recv_ok ? rd_data_r[3:0] : '0;
      out_active_mailboxes <= active_nxt;
      out_total_queued <= queued_nxt;
      out_total_sent   <= enq_ok ? sent_r + 32'd1 : sent_r;
    end
  end
endmodule

// ----- rtl/multi_queue_mailbox_engine_core.sv -----
// Multi-queue mailbox engine: per-slot message rings with owner tags, one
// command in and one result out per transfer. After the input transfer, the
// load step captures the command and reads the slot's head entry from the
// synchronous ring memory, then the execute step updates slot state, writes
// the ring and registers the result, which is then valid. The input stalls
// until the result transfer completes and is taken again the cycle after, so
// no new command is taken while one is in flight or its result is stalled.
// Configuration writes are always accepted and belong between commands.
module multi_queue_mailbox_engine_core #(
  parameter int MAILBOX_SLOTS = 16,
  parameter int RING_DEPTH    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_caller_id,
  input  logic [3:0]  in_target_slot,
  input  logic [31:0] in_target_id,
  input  logic [31:0] in_msg_kind,
  input  logic [31:0] in_tag,
  input  logic [63:0] in_payload,
  input  logic [7:0]  in_data_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_src_id,
  output logic [31:0] out_recv_kind,
  output logic [63:0] out_recv_payload,
  output logic [3:0]  out_recv_size,
  output logic [4:0]  out_active_mailboxes,
  output logic [8:0]  out_total_queued,
  output logic [31:0] out_total_sent
);
  import mqmb_pkg::*;

  dp_cmd_t dp_cmd;
  logic    tag_unused;

  assign cfg_ready  = 1'b1;
  assign tag_unused = ^in_tag;  // tag is not stored

  mqmb_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .dp_cmd
  );

  mqmb_datapath #(.MAILBOX_SLOTS(MAILBOX_SLOTS), .RING_DEPTH(RING_DEPTH)) u_dp (
    .clk, .rst_n, .dp_cmd,
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .in_cmd, .in_caller_id, .in_target_slot, .in_target_id, .in_msg_kind,
    .in_payload, .in_data_size,
    .out_status, .out_src_id, .out_recv_kind, .out_recv_payload, .out_recv_size,
    .out_active_mailboxes, .out_total_queued, .out_total_sent
  );
endmodule
